// File: design/slist_pkg.sv
// Shared operation codes and sequencer states for the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none

package slist_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [KindW-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_UPDATE  = 3'd3,
    OP_REVERSE = 3'd4
  } op_e;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_INS_RD  = 14'b00000000000010,
    ST_INS_CMP = 14'b00000000000100,
    ST_SHU_RD  = 14'b00000000001000,
    ST_SHU_WR  = 14'b00000000010000,
    ST_FND_RD  = 14'b00000000100000,
    ST_FND_CMP = 14'b00000001000000,
    ST_SHD_RD  = 14'b00000010000000,
    ST_SHD_WR  = 14'b00000100000000,
    ST_REV_A   = 14'b00001000000000,
    ST_REV_B   = 14'b00010000000000,
    ST_REV_C   = 14'b00100000000000,
    ST_REV_D   = 14'b01000000000000,
    ST_RESP    = 14'b10000000000000
  } state_e;

endpackage

`default_nettype wire

// File: design/slist_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module slist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/sorted_list_engine.sv
// Top level of the sorted list engine: sequencer around one table RAM.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid_i/ready_o  | kind_i, value_i, new_value_i
//  out     | out_valid_o/ready_i | found_o, position_o, full_drop_o,
//          |                     | entry_count_o
//
// One word at a time: a new word is taken only in the idle state. Each table
// step issues a read on the read port, then uses the registered read data.
// Reset clears the count and the handshake state; table contents need none.
// The result sits in an output register; a stalled output holds the
// sequencer in its response state and keeps in_ready_o low.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [slist_pkg::KindW-1:0] kind_i,
  input  wire logic signed [31:0]          value_i,
  input  wire logic signed [31:0]          new_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             found_o,
  output logic [slist_pkg::PosW-1:0]       position_o,
  output logic                             full_drop_o,
  output logic [slist_pkg::CountW-1:0]     entry_count_o
);

  import slist_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e             state_q, state_d;
  op_e                kind_q, kind_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] nv_q, nv_d;
  logic [31:0]        tmp_q, tmp_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      jdx_q, jdx_d;
  logic [CW-1:0]      count_q, count_d;
  logic               found_q, found_d;
  logic               drop_q, drop_d;
  logic               out_valid_q, out_valid_d;
  logic               res_found_q, res_found_d;
  logic [PosW-1:0]    res_pos_q, res_pos_d;
  logic               res_drop_q, res_drop_d;
  logic [CountW-1:0]  res_count_q, res_count_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [CW-1:0] jdx_dec;
  logic [CW-1:0] jdx_inc;
  logic [CW:0]   lo_inc;

  assign jdx_dec = jdx_q - CW'(1);
  assign jdx_inc = jdx_q + CW'(1);
  assign lo_inc  = {1'b0, idx_q} + (CW + 1)'(1);

  slist_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    val_d       = val_q;
    nv_d        = nv_q;
    tmp_d       = tmp_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    count_d     = count_q;
    found_d     = found_q;
    drop_d      = drop_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    res_drop_d  = res_drop_q;
    res_count_d = res_count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = op_e'(kind_i);
          val_d   = value_i;
          nv_d    = new_value_i;
          idx_d   = '0;
          jdx_d   = count_q;
          found_d = 1'b0;
          drop_d  = 1'b0;
          unique case (kind_i)
            OP_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                drop_d  = 1'b1;
                state_d = ST_RESP;
              end else begin
                state_d = ST_INS_RD;
              end
            end
            OP_DELETE, OP_SEARCH, OP_UPDATE: state_d = ST_FND_RD;
            OP_REVERSE:                      state_d = ST_REV_A;
            default:                         state_d = ST_RESP;
          endcase
        end
      end

      // Scan for the first entry greater than the value.
      ST_INS_RD: begin
        ram_raddr = idx_q[AW-1:0];
        if (idx_q == count_q) begin
          jdx_d   = count_q;
          state_d = ST_SHU_RD;
        end else begin
          state_d = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        if ($signed(ram_rdata) <= val_q) begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_INS_RD;
        end else begin
          jdx_d   = count_q;
          state_d = ST_SHU_RD;
        end
      end

      // Shift the tail up by one, then drop the value into the gap.
      ST_SHU_RD: begin
        ram_raddr = jdx_dec[AW-1:0];
        if (jdx_q == idx_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = ST_RESP;
        end else begin
          state_d = ST_SHU_WR;
        end
      end

      ST_SHU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_q[AW-1:0];
        ram_wdata = ram_rdata;
        jdx_d     = jdx_dec;
        state_d   = ST_SHU_RD;
      end

      ST_FND_RD: begin
        ram_raddr = idx_q[AW-1:0];
        if (idx_q == count_q) begin
          idx_d   = '0;
          state_d = ST_RESP;
        end else begin
          state_d = ST_FND_CMP;
        end
      end

      ST_FND_CMP: begin
        if ($signed(ram_rdata) == val_q) begin
          found_d = 1'b1;
          jdx_d   = idx_q;
          state_d = (kind_q == OP_SEARCH) ? ST_RESP : ST_SHD_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_FND_RD;
        end
      end

      // Close the gap left by the matched entry.
      ST_SHD_RD: begin
        ram_raddr = jdx_inc[AW-1:0];
        if (jdx_inc == count_q) begin
          count_d = count_q - CW'(1);
          if (kind_q == OP_UPDATE) begin
            val_d   = nv_q;
            idx_d   = '0;
            state_d = ST_INS_RD;
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          state_d = ST_SHD_WR;
        end
      end

      ST_SHD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_q[AW-1:0];
        ram_wdata = ram_rdata;
        jdx_d     = jdx_inc;
        state_d   = ST_SHD_RD;
      end

      // Swap the outermost pair and walk inwards.
      ST_REV_A: begin
        ram_raddr = idx_q[AW-1:0];
        if (lo_inc < {1'b0, jdx_q}) begin
          jdx_d   = jdx_dec;
          state_d = ST_REV_B;
        end else begin
          idx_d   = '0;
          state_d = ST_RESP;
        end
      end

      ST_REV_B: begin
        tmp_d     = ram_rdata;
        ram_raddr = jdx_q[AW-1:0];
        state_d   = ST_REV_C;
      end

      ST_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = ST_REV_D;
      end

      ST_REV_D: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_q[AW-1:0];
        ram_wdata = tmp_q;
        idx_d     = idx_q + CW'(1);
        state_d   = ST_REV_A;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_found_d = found_q;
          res_pos_d   = (found_q || kind_q == OP_INSERT) && !drop_q ? PosW'(idx_q) : '0;
          res_drop_d  = drop_q;
          res_count_d = CountW'(count_q);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    val_q       <= val_d;
    nv_q        <= nv_d;
    tmp_q       <= tmp_d;
    idx_q       <= idx_d;
    jdx_q       <= jdx_d;
    found_q     <= found_d;
    drop_q      <= drop_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    res_drop_q  <= res_drop_d;
    res_count_q <= res_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_found_q;
  assign position_o    = res_pos_q;
  assign full_drop_o   = res_drop_q;
  assign entry_count_o = res_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_found_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_found_q && res_drop_q))
    else $error("result both matched and dropped");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_drop_q) |-> (res_count_q == CountW'(CAPACITY)))
    else $error("insert dropped while table not full");

  a_resp_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished word not posted to output");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_ready_o)
    else $error("table written while idle");

endmodule

`default_nettype wire

// File: verif/slist_checker.sv
// Scoreboard for the sorted list engine: shadows the table and checks every result word.
`timescale 1ns / 1ps

module slist_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [slist_pkg::KindW-1:0]         kind_i,
  input  logic signed [slist_pkg::ValueW-1:0] value_i,
  input  logic signed [slist_pkg::ValueW-1:0] new_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                found_i,
  input  logic [slist_pkg::PosW-1:0]          position_i,
  input  logic                                full_drop_i,
  input  logic [slist_pkg::CountW-1:0]        entry_count_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         outstanding_o
);

  import slist_pkg::*;

  typedef struct packed {
    logic              found;
    logic [PosW-1:0]   position;
    logic              full_drop;
    logic [CountW-1:0] entry_count;
  } reply_t;

  logic signed [ValueW-1:0] slots [CAPACITY];
  int                       used;
  reply_t                   replies_q [$];

  function automatic int slot_of(logic signed [ValueW-1:0] v);
    for (int i = 0; i < used; i++) begin
      if (slots[i] == v) return i;
    end
    return -1;
  endfunction

  // Scan the physical order from the front; equal entries stay ahead of the new one.
  function automatic int place_value(logic signed [ValueW-1:0] v);
    int pos;
    if (used >= CAPACITY) return -1;
    pos = 0;
    while (pos < used && slots[pos] <= v) pos++;
    for (int i = used; i > pos; i--) slots[i] = slots[i-1];
    slots[pos] = v;
    used++;
    return pos;
  endfunction

  function automatic int remove_value(logic signed [ValueW-1:0] v);
    int hit;
    hit = slot_of(v);
    if (hit < 0) return -1;
    for (int i = hit; i + 1 < used; i++) slots[i] = slots[i+1];
    used--;
    return hit;
  endfunction

  function automatic void flip_slots();
    logic signed [ValueW-1:0] t;
    for (int lo = 0; lo < used / 2; lo++) begin
      t                 = slots[lo];
      slots[lo]         = slots[used-1-lo];
      slots[used-1-lo]  = t;
    end
  endfunction

  function automatic reply_t predict_reply(logic [KindW-1:0] kind,
                                           logic signed [ValueW-1:0] v,
                                           logic signed [ValueW-1:0] nv);
    reply_t r;
    int     hit;
    r = '0;
    case (kind)
      OP_INSERT: begin
        hit = place_value(v);
        if (hit < 0) r.full_drop = 1'b1;
        else r.position = PosW'(hit);
      end
      OP_DELETE: begin
        hit = remove_value(v);
        if (hit >= 0) begin
          r.found    = 1'b1;
          r.position = PosW'(hit);
        end
      end
      OP_SEARCH: begin
        hit = slot_of(v);
        if (hit >= 0) begin
          r.found    = 1'b1;
          r.position = PosW'(hit);
        end
      end
      OP_UPDATE: begin
        // only a matched old value lets the new one in
        hit = remove_value(v);
        if (hit >= 0) begin
          r.found = 1'b1;
          hit = place_value(nv);
          if (hit >= 0) r.position = PosW'(hit);
        end
      end
      OP_REVERSE: flip_slots();
      default: ;
    endcase
    r.entry_count = CountW'(used);
    return r;
  endfunction

  function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    int     errs;
    if (!rst_ni) begin
      used = 0;
      replies_q.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      // the result word leaving now always belongs to an earlier input word
      if (out_valid_i && out_ready_i) begin
        if (replies_q.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual %b/%0d/%b/%0d",
                   $time, found_i, position_i, full_drop_i, entry_count_i);
          errs++;
        end else begin
          want = replies_q.pop_front();
          errs += field_check("found", want.found, found_i);
          errs += field_check("position", want.position, position_i);
          errs += field_check("full_drop", want.full_drop, full_drop_i);
          errs += field_check("entry_count", want.entry_count, entry_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_q.push_back(predict_reply(kind_i, value_i, new_value_i));
      end
      mismatches_o  <= mismatches_o + errs;
      outstanding_o <= replies_q.size();
    end
  end

endmodule

// File: verif/tb_sorted_list_engine.sv
// Testbench top for the sorted list engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sorted_list_engine;
  import slist_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int          WORDS_TOTAL  = 1450;
  localparam int          POOL_SIZE    = 12;
  localparam int          LONG_HOLD_AT = 400;
  localparam int          LONG_HOLD    = 300;
  localparam int          TAIL_CYCLES  = 300;

  localparam logic [KindW-1:0]         KIND_SPARE_FIRST = 3'd5;
  localparam logic [KindW-1:0]         KIND_SPARE_LAST  = 3'd7;
  localparam logic signed [ValueW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                     clk_i = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KindW-1:0]         kind = '0;
  logic signed [ValueW-1:0] value = '0;
  logic signed [ValueW-1:0] new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     found;
  logic [PosW-1:0]          position;
  logic                     full_drop;
  logic [CountW-1:0]        entry_count;
  int unsigned              mismatches;
  int unsigned              outstanding;

  logic signed [ValueW-1:0] pool [POOL_SIZE];
  bit                       send_quiet;
  int                       words_sent;

  always #10 clk_i = ~clk_i;

  sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .value_i       (value),
    .new_value_i   (new_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found),
    .position_o    (position),
    .full_drop_o   (full_drop),
    .entry_count_o (entry_count)
  );

  slist_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .value_i       (value),
    .new_value_i   (new_value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_i       (found),
    .position_i    (position),
    .full_drop_i   (full_drop),
    .entry_count_i (entry_count),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  task automatic send_word(input logic [KindW-1:0] k, input logic signed [ValueW-1:0] v,
                           input logic signed [ValueW-1:0] nv);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    value     <= v;
    new_value <= nv;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  // Hold the input side until every predicted result word has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE / 2) pool[i] = $urandom_range(0, 40) - 20;
      else pool[i] = $urandom();
    end
  endtask

  // Mostly pool values so that deletes, searches and updates find their targets.
  function automatic logic signed [ValueW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 63) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [KindW-1:0] pick_kind(int ins_pct, int del_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return OP_INSERT;
    if (r < ins_pct + del_pct) return OP_DELETE;
    r = $urandom_range(0, 19);
    if (r < 7) return OP_SEARCH;
    if (r < 14) return OP_UPDATE;
    if (r < 18) return OP_REVERSE;
    return KindW'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
  endfunction

  task automatic run_directed();
    // empty table: misses and a reverse with nothing to flip
    send_word(OP_SEARCH, 5, 0);
    send_word(OP_DELETE, 5, 0);
    send_word(OP_UPDATE, 5, 7);
    send_word(OP_REVERSE, 0, 0);
    send_word(OP_INSERT, 0, 0);
    send_word(OP_REVERSE, 0, 0);
    send_word(OP_INSERT, VAL_MAX, VAL_MIN);
    send_word(OP_INSERT, VAL_MIN, VAL_MAX);
    send_word(OP_INSERT, -1, 0);
    send_word(OP_INSERT, 0, -1);
    send_word(OP_SEARCH, 0, 0);
    send_word(OP_SEARCH, VAL_MIN, 0);
    send_word(OP_UPDATE, -1, VAL_MAX);
    send_word(OP_DELETE, VAL_MAX, 0);
    // inserts after a reverse still scan the physical order
    send_word(OP_REVERSE, 0, 0);
    send_word(OP_INSERT, 3, 0);
    send_word(OP_SEARCH, 3, 0);
    send_word(OP_UPDATE, 12345, 1);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_word(KindW'(k), $urandom(), $urandom());
    end
    send_word(OP_DELETE, VAL_MIN, 0);
    send_word(OP_UPDATE, VAL_MAX, $urandom());
  endtask

  initial begin : stimulus
    int phase_len;
    int mode;
    int ins_pct;
    int del_pct;
    words_sent = 0;
    send_quiet = 1'b0;
    refresh_pool();
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain_results();

    // fill past capacity so that overflowing inserts are dropped
    send_quiet = 1'b1;
    repeat (CAPACITY + 8) send_word(OP_INSERT, pick_value(), pick_value());
    send_quiet = 1'b0;
    drain_results();

    while (words_sent < WORDS_TOTAL) begin
      refresh_pool();
      mode       = $urandom_range(0, 2);
      send_quiet = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(40, 120);
      case (mode)
        0:       begin ins_pct = 60; del_pct = 12; end
        1:       begin ins_pct = 15; del_pct = 45; end
        default: begin ins_pct = 35; del_pct = 25; end
      endcase
      repeat (phase_len) send_word(pick_kind(ins_pct, del_pct), pick_value(), pick_value());
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_side
    int  hold;
    int  taken;
    bit  take_quiet;
    taken      = 0;
    take_quiet = 1'b0;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (taken % 60 == 0) take_quiet = ($urandom_range(0, 3) == 0);
      hold = take_quiet ? 0 : $urandom_range(0, 6);
      // one long stall so the engine backs up onto its input
      if (taken == LONG_HOLD_AT) hold = LONG_HOLD;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
